>>> hdl/matrix3x3_inverse_macros.svh
// ----------------------------------------------------------------------------
// Matrix inverse assertion macros
// Shared concurrent assertion forms for the 3x3 inverse pipeline.
// ----------------------------------------------------------------------------
`ifndef MATRIX3X3_INVERSE_MACROS_SVH
`define MATRIX3X3_INVERSE_MACROS_SVH

// Implication in the same cycle.
`define M3I_ASSERT_NOW(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// Implication in the next cycle.
`define M3I_ASSERT_NEXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

>>> hdl/m3i_pkg.sv
// ----------------------------------------------------------------------------
// m3i_pkg
// Widths, types and tables shared by the 3x3 matrix inverse pipeline.
// ----------------------------------------------------------------------------
package m3i_pkg;

   localparam int ENTRY_WIDTH = 32;
   localparam int FRAC_BITS   = 16;

   localparam int PROD_W = 2 * ENTRY_WIDTH;
   localparam int ADJ_W  = PROD_W + 1;
   localparam int DET_W  = 3 * ENTRY_WIDTH + 1;
   localparam int NUMA_W = ADJ_W + 2 * FRAC_BITS + 2;
   localparam int NUM_W  = (NUMA_W > DET_W + 1) ? NUMA_W : DET_W + 1;
   localparam int QUO_W  = ENTRY_WIDTH;
   localparam int CMP_W  = NUM_W + QUO_W;

   localparam int N_COF_ST = 2;
   localparam int N_DET_ST = 5;
   localparam int N_DIV_ST = QUO_W + 1;
   localparam int N_ST     = N_COF_ST + N_DET_ST + N_DIV_ST + 1;

   typedef logic signed [ENTRY_WIDTH-1:0] entry_type;
   typedef logic signed [PROD_W-1:0]      prod_type;
   typedef logic signed [ADJ_W-1:0]       adj_type;
   typedef logic signed [DET_W-1:0]       det_type;
   typedef logic [ADJ_W-1:0]              mag_type;
   typedef logic [NUM_W-1:0]              num_type;
   typedef logic [QUO_W-1:0]              quo_type;

   localparam entry_type ENTRY_MAX = {1'b0, {(ENTRY_WIDTH-1){1'b1}}};
   localparam entry_type ENTRY_MIN = {1'b1, {(ENTRY_WIDTH-1){1'b0}}};

   // Row-major operand indices of each cofactor: C = m[a]*m[b] - m[c]*m[d].
   // Entry k is already placed at its transposed (adjugate) position.
   localparam logic [3:0] COF_IDX [9][4] = '{
      '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
      '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
      '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
   };

endpackage

>>> hdl/m3i_cofactor.sv
// ----------------------------------------------------------------------------
// m3i_cofactor
// Two stages: the eighteen entry products, then the nine adjugate entries.
// ----------------------------------------------------------------------------
module m3i_cofactor (
   input  logic                            clock,
   input  logic [m3i_pkg::N_COF_ST-1:0]    stage_en,
   input  m3i_pkg::entry_type              mat_in [9],
   output m3i_pkg::adj_type                adj_out [9],
   output m3i_pkg::entry_type              row_out [3]
);
   import m3i_pkg::*;

   prod_type  prod_a_in [9];
   prod_type  prod_b_in [9];
   prod_type  prod_a_ff [9];
   prod_type  prod_b_ff [9];
   entry_type row1_ff [3];
   adj_type   adj_in [9];
   adj_type   adj_ff [9];
   entry_type row2_ff [3];

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         prod_a_in[k] = mat_in[COF_IDX[k][0]] * mat_in[COF_IDX[k][1]];
         prod_b_in[k] = mat_in[COF_IDX[k][2]] * mat_in[COF_IDX[k][3]];
      end
   end

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         adj_in[k] = adj_type'(prod_a_ff[k]) - adj_type'(prod_b_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         prod_a_ff <= prod_a_in;
         prod_b_ff <= prod_b_in;
         row1_ff   <= mat_in[0:2];
      end
      if (stage_en[1]) begin
         adj_ff  <= adj_in;
         row2_ff <= row1_ff;
      end
   end

   assign adj_out = adj_ff;
   assign row_out = row2_ff;

endmodule

>>> hdl/m3i_det.sv
// ----------------------------------------------------------------------------
// m3i_det
// Five stages: determinant by first-row expansion, magnitude, and the
// rounded numerators and shared divisor for the nine quotients.
// ----------------------------------------------------------------------------
module m3i_det (
   input  logic                            clock,
   input  logic [m3i_pkg::N_DET_ST-1:0]    stage_en,
   input  m3i_pkg::adj_type                adj_in [9],
   input  m3i_pkg::entry_type              row_in [3],
   output m3i_pkg::num_type                num_out [9],
   output logic                            neg_out [9],
   output m3i_pkg::num_type                div_out,
   output logic                            singular_out
);
   import m3i_pkg::*;

   logic signed [ADJ_W-1:0] plo_in [3];
   logic signed [ADJ_W-1:0] phi_in [3];
   logic signed [ADJ_W-1:0] plo_ff [3];
   logic signed [ADJ_W-1:0] phi_ff [3];
   det_type  term_in [3];
   det_type  term_ff [3];
   det_type  det_ff;
   logic [DET_W-1:0] dmag_in;
   logic [DET_W-1:0] dmag_ff;
   logic     dneg_ff;
   logic     sing6_ff;
   logic     sing7_ff;
   mag_type  mag_in [9];
   mag_type  mag_ff [4][9];
   logic     aneg_in [9];
   logic     aneg_ff [4][9];
   num_type  num_in [9];
   num_type  num_ff [9];
   logic     neg_in [9];
   logic     neg_ff [9];
   num_type  div_ff;

   // The cofactor is split into an unsigned low word and a signed high part
   // so that each multiplier stays one entry wide.
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         plo_in[j] = row_in[j] * $signed({1'b0, adj_in[3*j][ENTRY_WIDTH-1:0]});
         phi_in[j] = row_in[j] * $signed(adj_in[3*j][ADJ_W-1:ENTRY_WIDTH]);
      end
      for (int k = 0; k < 9; k++) begin
         aneg_in[k] = adj_in[k][ADJ_W-1];
         mag_in[k]  = adj_in[k][ADJ_W-1] ? mag_type'(-adj_in[k]) : mag_type'(adj_in[k]);
      end
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         term_in[j] = (det_type'(phi_ff[j]) <<< ENTRY_WIDTH) + det_type'(plo_ff[j]);
      end
   end

   // A zero determinant is replaced by one in the product format.
   always_comb begin
      if (det_ff == '0) begin
         dmag_in = DET_W'(1) << (3 * FRAC_BITS);
      end else if (det_ff[DET_W-1]) begin
         dmag_in = DET_W'(-det_ff);
      end else begin
         dmag_in = DET_W'(det_ff);
      end
   end

   // Numerator 2*|adj|*2^2F + |det| over 2*|det| rounds half away from zero.
   always_comb begin
      for (int k = 0; k < 9; k++) begin
         num_in[k] = (NUM_W'(mag_ff[3][k]) << (2 * FRAC_BITS + 1)) + NUM_W'(dmag_ff);
         neg_in[k] = aneg_ff[3][k] ^ dneg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         plo_ff     <= plo_in;
         phi_ff     <= phi_in;
         mag_ff[0]  <= mag_in;
         aneg_ff[0] <= aneg_in;
      end
      if (stage_en[1]) begin
         term_ff    <= term_in;
         mag_ff[1]  <= mag_ff[0];
         aneg_ff[1] <= aneg_ff[0];
      end
      if (stage_en[2]) begin
         det_ff     <= term_ff[0] + term_ff[1] + term_ff[2];
         mag_ff[2]  <= mag_ff[1];
         aneg_ff[2] <= aneg_ff[1];
      end
      if (stage_en[3]) begin
         dmag_ff    <= dmag_in;
         dneg_ff    <= det_ff[DET_W-1];
         sing6_ff   <= (det_ff == '0);
         mag_ff[3]  <= mag_ff[2];
         aneg_ff[3] <= aneg_ff[2];
      end
      if (stage_en[4]) begin
         num_ff   <= num_in;
         neg_ff   <= neg_in;
         div_ff   <= NUM_W'(dmag_ff) << 1;
         sing7_ff <= sing6_ff;
      end
   end

   assign num_out      = num_ff;
   assign neg_out      = neg_ff;
   assign div_out      = div_ff;
   assign singular_out = sing7_ff;

endmodule

>>> hdl/m3i_div.sv
// ----------------------------------------------------------------------------
// m3i_div
// Pipelined restoring divider, nine lanes sharing one divisor. The first
// stage flags quotients too large for an entry; each later stage settles
// one quotient bit.
// ----------------------------------------------------------------------------
module m3i_div (
   input  logic                            clock,
   input  logic [m3i_pkg::N_DIV_ST-1:0]    stage_en,
   input  m3i_pkg::num_type                num_in [9],
   input  logic                            neg_in [9],
   input  m3i_pkg::num_type                div_in,
   input  logic                            singular_in,
   output m3i_pkg::quo_type                quo_out [9],
   output logic                            big_out [9],
   output logic                            neg_out [9],
   output logic                            singular_out
);
   import m3i_pkg::*;

   num_type rem_ff  [N_DIV_ST][9];
   quo_type quo_ff  [N_DIV_ST][9];
   logic    big_ff  [N_DIV_ST][9];
   logic    neg_ff  [N_DIV_ST][9];
   num_type div_ff  [N_DIV_ST];
   logic    sing_ff [N_DIV_ST];
   logic    big_in  [9];

   always_comb begin
      for (int l = 0; l < 9; l++) begin
         big_in[l] = CMP_W'(num_in[l]) >= (CMP_W'(div_in) << QUO_W);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         rem_ff[0]  <= num_in;
         quo_ff[0]  <= '{default: '0};
         big_ff[0]  <= big_in;
         neg_ff[0]  <= neg_in;
         div_ff[0]  <= div_in;
         sing_ff[0] <= singular_in;
      end
   end

   for (genvar s = 1; s < N_DIV_ST; s++) begin : g_step
      localparam int BIT = QUO_W - s;
      logic [CMP_W-1:0] shifted;
      num_type rem_in [9];
      quo_type quo_in [9];

      assign shifted = CMP_W'(div_ff[s-1]) << BIT;

      always_comb begin
         for (int l = 0; l < 9; l++) begin
            if (CMP_W'(rem_ff[s-1][l]) >= shifted) begin
               rem_in[l] = rem_ff[s-1][l] - NUM_W'(shifted);
               quo_in[l] = quo_ff[s-1][l] | (QUO_W'(1) << BIT);
            end else begin
               rem_in[l] = rem_ff[s-1][l];
               quo_in[l] = quo_ff[s-1][l];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (stage_en[s]) begin
            rem_ff[s]  <= rem_in;
            quo_ff[s]  <= quo_in;
            big_ff[s]  <= big_ff[s-1];
            neg_ff[s]  <= neg_ff[s-1];
            div_ff[s]  <= div_ff[s-1];
            sing_ff[s] <= sing_ff[s-1];
         end
      end
   end

   assign quo_out      = quo_ff[N_DIV_ST-1];
   assign big_out      = big_ff[N_DIV_ST-1];
   assign neg_out      = neg_ff[N_DIV_ST-1];
   assign singular_out = sing_ff[N_DIV_ST-1];

endmodule

>>> hdl/matrix3x3_inverse.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// Inverse of a 3x3 signed Q16.16 matrix by adjugate over determinant.
//
// A request carries the nine entries in row order on req_in_*. It is taken
// at a rising edge with req_valid high and req_stall low. The response
// gives the nine inverse entries, rounded to nearest with ties away from
// zero and saturated, plus rsp_singular (zero determinant, unscaled
// adjugate returned) and rsp_overflow (some entry saturated).
// Two cofactor stages, five determinant stages, thirty-three divider
// stages (a range check, then one quotient bit each) and the output
// register. One request is taken every cycle while req_stall is low.
// When rsp_stall is high the response holds and requests keep entering
// until the pipeline is full; only then is req_stall raised, in the same
// cycle. Synchronous reset empties the pipeline; there is no other state.
// ----------------------------------------------------------------------------
`include "matrix3x3_inverse_macros.svh"

module matrix3x3_inverse (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  m3i_pkg::entry_type req_in_r1c1,
   input  m3i_pkg::entry_type req_in_r1c2,
   input  m3i_pkg::entry_type req_in_r1c3,
   input  m3i_pkg::entry_type req_in_r2c1,
   input  m3i_pkg::entry_type req_in_r2c2,
   input  m3i_pkg::entry_type req_in_r2c3,
   input  m3i_pkg::entry_type req_in_r3c1,
   input  m3i_pkg::entry_type req_in_r3c2,
   input  m3i_pkg::entry_type req_in_r3c3,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output m3i_pkg::entry_type rsp_inv_r1c1,
   output m3i_pkg::entry_type rsp_inv_r1c2,
   output m3i_pkg::entry_type rsp_inv_r1c3,
   output m3i_pkg::entry_type rsp_inv_r2c1,
   output m3i_pkg::entry_type rsp_inv_r2c2,
   output m3i_pkg::entry_type rsp_inv_r2c3,
   output m3i_pkg::entry_type rsp_inv_r3c1,
   output m3i_pkg::entry_type rsp_inv_r3c2,
   output m3i_pkg::entry_type rsp_inv_r3c3,
   output logic               rsp_singular,
   output logic               rsp_overflow
);
   import m3i_pkg::*;

   localparam int DET_LO = N_COF_ST;
   localparam int DIV_LO = N_COF_ST + N_DET_ST;
   localparam int OUT_ST = N_ST - 1;

   logic [N_ST-1:0] valid_ff;
   logic [N_ST-1:0] valid_in;
   logic [N_ST-1:0] stage_en;
   logic [N_ST-1:0] all_ones;

   entry_type mat [9];
   adj_type   adj [9];
   entry_type row [3];
   num_type   num [9];
   logic      num_neg [9];
   num_type   divisor;
   logic      det_sing;
   quo_type   quo [9];
   logic      big [9];
   logic      quo_neg [9];
   logic      div_sing;

   entry_type res_in [9];
   entry_type res_ff [9];
   logic      ovf_in;
   logic      ovf_ff;
   logic      sing_ff;

   assign mat[0] = req_in_r1c1;
   assign mat[1] = req_in_r1c2;
   assign mat[2] = req_in_r1c3;
   assign mat[3] = req_in_r2c1;
   assign mat[4] = req_in_r2c2;
   assign mat[5] = req_in_r2c3;
   assign mat[6] = req_in_r3c1;
   assign mat[7] = req_in_r3c2;
   assign mat[8] = req_in_r3c3;

   // A stage moves unless it and every stage after it hold a request while
   // the output is stalled, so bubbles are squeezed out.
   assign all_ones = '1;
   always_comb begin
      for (int k = 0; k < N_ST; k++) begin
         stage_en[k] = !rsp_stall || ((valid_ff >> k) != (all_ones >> k));
      end
   end

   assign valid_in  = {valid_ff[N_ST-2:0], req_valid};
   assign req_stall = !stage_en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < N_ST; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   m3i_cofactor u_cofactor (
      .clock    (clock),
      .stage_en (stage_en[DET_LO-1:0]),
      .mat_in   (mat),
      .adj_out  (adj),
      .row_out  (row)
   );

   m3i_det u_det (
      .clock        (clock),
      .stage_en     (stage_en[DIV_LO-1:DET_LO]),
      .adj_in       (adj),
      .row_in       (row),
      .num_out      (num),
      .neg_out      (num_neg),
      .div_out      (divisor),
      .singular_out (det_sing)
   );

   m3i_div u_div (
      .clock        (clock),
      .stage_en     (stage_en[OUT_ST-1:DIV_LO]),
      .num_in       (num),
      .neg_in       (num_neg),
      .div_in       (divisor),
      .singular_in  (det_sing),
      .quo_out      (quo),
      .big_out      (big),
      .neg_out      (quo_neg),
      .singular_out (div_sing)
   );

   // Sign and saturation. A negative result may reach one step further.
   always_comb begin
      ovf_in = 1'b0;
      for (int l = 0; l < 9; l++) begin
         if (quo_neg[l]) begin
            if (big[l] || (quo[l][QUO_W-1] && (|quo[l][QUO_W-2:0]))) begin
               res_in[l] = ENTRY_MIN;
               ovf_in    = 1'b1;
            end else begin
               res_in[l] = entry_type'(QUO_W'(0) - quo[l]);
            end
         end else begin
            if (big[l] || quo[l][QUO_W-1]) begin
               res_in[l] = ENTRY_MAX;
               ovf_in    = 1'b1;
            end else begin
               res_in[l] = entry_type'(quo[l]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[OUT_ST]) begin
         res_ff  <= res_in;
         ovf_ff  <= ovf_in;
         sing_ff <= div_sing;
      end
   end

   assign rsp_valid    = valid_ff[OUT_ST];
   assign rsp_inv_r1c1 = res_ff[0];
   assign rsp_inv_r1c2 = res_ff[1];
   assign rsp_inv_r1c3 = res_ff[2];
   assign rsp_inv_r2c1 = res_ff[3];
   assign rsp_inv_r2c2 = res_ff[4];
   assign rsp_inv_r2c3 = res_ff[5];
   assign rsp_inv_r3c1 = res_ff[6];
   assign rsp_inv_r3c2 = res_ff[7];
   assign rsp_inv_r3c3 = res_ff[8];
   assign rsp_singular = sing_ff;
   assign rsp_overflow = ovf_ff;

   `M3I_ASSERT_NOW(a_stall_only_full, req_stall, (&valid_ff) && rsp_stall, "request stalled with room in the pipeline")
   `M3I_ASSERT_NEXT(a_request_enters, req_valid && !req_stall, valid_ff[0], "accepted request did not enter the first stage")
   `M3I_ASSERT_NEXT(a_response_drains, rsp_valid && !rsp_stall && !valid_ff[OUT_ST-1], !rsp_valid, "response repeated after it was taken")

endmodule

>>> test/matrix3x3_inverse_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix3x3_inverse_tb
// Streams 3x3 Q16.16 matrices into the inverse pipeline with random gaps and
// response stalls, and checks every response against an exact adjugate over
// determinant computation done here in wide integer arithmetic.
// ----------------------------------------------------------------------------
module matrix3x3_inverse_tb;

   import m3i_pkg::*;

   localparam int F = FRAC_BITS;
   localparam int W = 256;

   typedef struct {
      entry_type m [9];
   } matrix_req_type;

   typedef struct {
      entry_type inv [9];
      logic      singular;
      logic      overflow;
   } inverse_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   entry_type req_in [9];
   entry_type rsp_inv [9];
   logic rsp_singular, rsp_overflow;

   matrix_req_type pending_reqs [$];
   inverse_type    expected_inverses [$];
   int          fail_count = 0;
   int          idle_left = 0;
   int          stall_left = 0;
   bit          calm = 1'b0;
   bit          stim_done = 1'b0;
   bit          req_taken = 1'b0;

   initial begin
      foreach (req_in[k]) req_in[k] = '0;
   end

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   matrix3x3_inverse u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_in_r1c1(req_in[0]), .req_in_r1c2(req_in[1]), .req_in_r1c3(req_in[2]),
      .req_in_r2c1(req_in[3]), .req_in_r2c2(req_in[4]), .req_in_r2c3(req_in[5]),
      .req_in_r3c1(req_in[6]), .req_in_r3c2(req_in[7]), .req_in_r3c3(req_in[8]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_inv_r1c1(rsp_inv[0]), .rsp_inv_r1c2(rsp_inv[1]), .rsp_inv_r1c3(rsp_inv[2]),
      .rsp_inv_r2c1(rsp_inv[3]), .rsp_inv_r2c2(rsp_inv[4]), .rsp_inv_r2c3(rsp_inv[5]),
      .rsp_inv_r3c1(rsp_inv[6]), .rsp_inv_r3c2(rsp_inv[7]), .rsp_inv_r3c3(rsp_inv[8]),
      .rsp_singular(rsp_singular), .rsp_overflow(rsp_overflow)
   );

   // Exact inverse: cofactors and determinant in wide signed integers, then a
   // rounded (ties away from zero) quotient saturated to the entry range.
   function automatic inverse_type invert_matrix(matrix_req_type r);
      logic signed [W-1:0] a [9];
      logic signed [W-1:0] cof [9];
      logic signed [W-1:0] det, num;
      logic [W-1:0] dmag, nmag, q;
      logic [W-1:0] lim_pos, lim_neg;
      bit neg;
      inverse_type res;
      lim_pos = (W'(1) << (ENTRY_WIDTH - 1)) - 1;
      lim_neg = W'(1) << (ENTRY_WIDTH - 1);
      foreach (a[k]) a[k] = W'(r.m[k]);
      cof[0] = a[4] * a[8] - a[5] * a[7];
      cof[1] = a[2] * a[7] - a[1] * a[8];
      cof[2] = a[1] * a[5] - a[2] * a[4];
      cof[3] = a[5] * a[6] - a[3] * a[8];
      cof[4] = a[0] * a[8] - a[2] * a[6];
      cof[5] = a[2] * a[3] - a[0] * a[5];
      cof[6] = a[3] * a[7] - a[4] * a[6];
      cof[7] = a[1] * a[6] - a[0] * a[7];
      cof[8] = a[0] * a[4] - a[1] * a[3];
      det = a[0] * cof[0] + a[1] * cof[3] + a[2] * cof[6];
      res.singular = (det == 0);
      if (res.singular) det = W'(1) << (3 * F);
      dmag = det < 0 ? -det : det;
      res.overflow = 1'b0;
      for (int k = 0; k < 9; k++) begin
         num = cof[k] <<< (2 * F);
         nmag = num < 0 ? -num : num;
         neg = (num < 0) != (det < 0);
         q = (2 * nmag + dmag) / (2 * dmag);
         if (neg) begin
            if (q > lim_neg) begin
               q = lim_neg;
               res.overflow = 1'b1;
            end
            q = -q;
         end else if (q > lim_pos) begin
            q = lim_pos;
            res.overflow = 1'b1;
         end
         res.inv[k] = entry_type'(q[ENTRY_WIDTH-1:0]);
      end
      return res;
   endfunction

   function automatic entry_type pick_entry();
      case ($urandom_range(0, 5))
         0: return entry_type'($urandom);
         1: return entry_type'($urandom_range(0, 4 << F)) - entry_type'(2 << F);
         2: return ($urandom_range(0, 1) ? ENTRY_MAX : ENTRY_MIN);
         3: return entry_type'($urandom_range(0, 255)) - entry_type'(128);
         4: return entry_type'({$urandom_range(0, 64), 16'h0}) - entry_type'(32 << F);
         default: return entry_type'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      endcase
   endfunction

   // Driver: inputs move on the falling edge only. The monitor tells it
   // whether the request on the port was taken at the last rising edge.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken) void'(pending_reqs.pop_front());
         if (req_valid && !req_taken) begin
            // Payload holds while stalled.
         end else if (idle_left > 0) begin
            idle_left <= idle_left - 1;
            req_valid <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            idle_left <= $urandom_range(0, 2);
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_valid <= 1'b1;
            foreach (req_in[k]) req_in[k] <= pending_reqs[0].m[k];
         end else begin
            req_valid <= 1'b0;
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Monitor: requests and responses are taken at the rising edge.
   always @(posedge clock) begin
      inverse_type exp_inv;
      req_taken = !reset && req_valid && !req_stall;
      if (!reset) begin
         if (req_taken)
            expected_inverses.push_back(invert_matrix(pending_reqs[0]));
         if (rsp_valid && !rsp_stall) begin
            if (expected_inverses.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               exp_inv = expected_inverses.pop_front();
               for (int k = 0; k < 9; k++)
                  if (rsp_inv[k] !== exp_inv.inv[k]) begin
                     $error("inv_r%0dc%0d expected %h got %h", k / 3 + 1, k % 3 + 1,
                            exp_inv.inv[k], rsp_inv[k]);
                     fail_count++;
                  end
               if (rsp_singular !== exp_inv.singular) begin
                  $error("singular expected %b got %b", exp_inv.singular, rsp_singular);
                  fail_count++;
               end
               if (rsp_overflow !== exp_inv.overflow) begin
                  $error("overflow expected %b got %b", exp_inv.overflow, rsp_overflow);
                  fail_count++;
               end
            end
         end
      end
   end

   task automatic add_matrix(input entry_type e [9]);
      matrix_req_type r;
      r.m = e;
      pending_reqs.push_back(r);
   endtask

   initial begin
      entry_type e [9];
      entry_type one;
      one = entry_type'(1 << F);
      repeat (11) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      // Directed: identity, scaled identity, zero, singular rows, extremes.
      e = '{one, 0, 0, 0, one, 0, 0, 0, one};                         add_matrix(e);
      e = '{2 * one, 0, 0, 0, -4 * one, 0, 0, 0, one / 2};            add_matrix(e);
      e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                               add_matrix(e);
      e = '{one, 2 * one, 3 * one, 2 * one, 4 * one, 6 * one, 1, 5, 9}; add_matrix(e);
      e = '{1, 0, 0, 0, 1, 0, 0, 0, 1};                               add_matrix(e);
      e = '{ENTRY_MAX, 0, 0, 0, ENTRY_MAX, 0, 0, 0, ENTRY_MAX};       add_matrix(e);
      e = '{ENTRY_MIN, 0, 0, 0, ENTRY_MIN, 0, 0, 0, ENTRY_MIN};       add_matrix(e);
      foreach (e[k]) e[k] = ENTRY_MAX;                                add_matrix(e);
      foreach (e[k]) e[k] = ENTRY_MIN;                                add_matrix(e);
      foreach (e[k]) e[k] = -1;                                       add_matrix(e);
      e = '{ENTRY_MIN, ENTRY_MAX, ENTRY_MIN, ENTRY_MAX, ENTRY_MIN, ENTRY_MAX,
            ENTRY_MIN, ENTRY_MAX, ENTRY_MAX};                         add_matrix(e);
      e = '{one, one, 0, 0, one, one, one, 0, one};                   add_matrix(e);
      e = '{3, 0, 0, 0, 3, 0, 0, 0, 3};                               add_matrix(e);
      e = '{one, 1, -1, 2, -one, 3, 0, 7, one};                       add_matrix(e);
      e = '{0, one, 0, one, 0, 0, 0, 0, -one};                        add_matrix(e);

      for (int n = 0; n < 750; n++) begin
         if ($urandom_range(0, 9) == 0) begin
            // Dependent rows give a zero determinant with nonzero cofactors.
            for (int k = 0; k < 3; k++) begin
               e[k] = entry_type'($urandom_range(0, 1 << 18)) - entry_type'(1 << 17);
               e[k + 3] = e[k] * 2;
               e[k + 6] = entry_type'($urandom);
            end
         end else begin
            foreach (e[k]) e[k] = pick_entry();
         end
         add_matrix(e);
         if (n == 650) begin
            wait (pending_reqs.size() < 20);
            calm = 1'b1;
         end
      end
      stim_done = 1'b1;
   end

   initial begin
      wait (stim_done && pending_reqs.size() == 0 && expected_inverses.size() == 0);
      repeat (60) @(posedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #200000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
